// ===== src/cache_tag_hit_miss_model_top_macros.svh =====
// Assertion macros for the cache tag hit/miss model checker.
// Used by the checker file only; needs nothing else.
`ifndef CACHE_TAG_HIT_MISS_MODEL_TOP_MACROS_SVH
`define CACHE_TAG_HIT_MISS_MODEL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTHM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cthm assertion failed");

// Next-cycle implication, checked outside reset.
`define CTHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cthm assertion failed");

`endif

// ===== src/cthm_pkg.sv =====
// Shared types and constants of the cache tag hit/miss model.
// No dependencies; used by every module of the block.
`default_nettype none

package cthm_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 22;
    localparam int RAW_IDX_W = 9;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 3;

    // Configuration register indexes.
    localparam logic [0:0] CFG_MODE         = 1'b0;
    localparam logic [0:0] CFG_BLOCK_OFFSET = 1'b1;

    // Access kinds.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Cache organizations.
    localparam logic MODE_DIRECT  = 1'b0;
    localparam logic MODE_TWO_WAY = 1'b1;

    localparam logic [2:0] MIN_OFFSET_BITS   = 3'd2;
    localparam logic [2:0] MAX_OFFSET_BITS   = 3'd6;
    localparam logic [2:0] RESET_OFFSET_BITS = 3'd2;

    // One set of the tag store.
    typedef struct packed {
        logic             v0;
        logic [TAG_W-1:0] t0;
        logic             v1;
        logic [TAG_W-1:0] t1;
        logic             recent;
    } set_entry_t;

    localparam set_entry_t ENTRY_RESET = '{v0: 1'b0, t0: '0, v1: 1'b0, t1: '0, recent: 1'b1};

    function automatic logic [2:0] eff_offset_bits(input logic [2:0] raw);
        logic [2:0] b;
        b = raw;
        if (b < MIN_OFFSET_BITS)
        begin
            b = MIN_OFFSET_BITS;
        end
        if (b > MAX_OFFSET_BITS)
        begin
            b = MAX_OFFSET_BITS;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/cthm_index.sv =====
// Address decode: set index and tag of a request for the current mode and block size.
// Depends on cthm_pkg.
`default_nettype none

module cthm_index #(
    parameter int MAX_SETS = 512
) (
    input  wire logic                               mode,
    input  wire logic [cthm_pkg::CFG_W-1:0]         offset_bits,
    input  wire logic [cthm_pkg::ADDR_W-1:0]        address,
    output logic      [$clog2(MAX_SETS)-1:0]        idx,
    output logic      [cthm_pkg::TAG_W-1:0]         tag
);

    localparam int IDX_W = $clog2(MAX_SETS);
    // Wide enough to hold MAX_SETS shifted by four for the reduction steps.
    localparam int RW    = IDX_W + 5;

    logic [2:0]                        b;
    logic [3:0]                        cap;
    logic [10:0]                       shifted;
    logic [10:0]                       mask;
    logic [10:0]                       raw_full;
    logic [cthm_pkg::RAW_IDX_W-1:0]    raw_idx;
    logic [RW-1:0]                     rem;

    always_comb
    begin
        b        = cthm_pkg::eff_offset_bits(offset_bits);
        cap      = (mode == cthm_pkg::MODE_TWO_WAY) ? 4'd11 : 4'd10;
        shifted  = address[10:0] >> b;
        mask     = (11'd1 << (cap - {1'b0, b})) - 11'd1;
        raw_full = shifted & mask;
        raw_idx  = raw_full[cthm_pkg::RAW_IDX_W-1:0];
    end

    // The raw index stays below 32 times MAX_SETS, so five conditional
    // subtractions of shifted copies of MAX_SETS leave the remainder.
    always_comb
    begin
        rem = RW'(raw_idx);
        for (int j = 4; j >= 0; j--)
        begin
            if (rem >= (RW'(MAX_SETS) << j))
            begin
                rem = rem - (RW'(MAX_SETS) << j);
            end
        end
    end

    assign idx = rem[IDX_W-1:0];
    assign tag = (mode == cthm_pkg::MODE_TWO_WAY) ? {1'b0, address[31:11]} : address[31:10];

endmodule

`default_nettype wire

// ===== src/cthm_tag_ram.sv =====
// Tag store: one synchronous memory of set entries with a registered read port,
// one write port and a clearing pass after reset. Depends on cthm_pkg.
`default_nettype none

module cthm_tag_ram #(
    parameter int MAX_SETS = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(MAX_SETS)-1:0]   rd_addr,
    output cthm_pkg::set_entry_t               rd_data,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(MAX_SETS)-1:0]   wr_addr,
    input  cthm_pkg::set_entry_t               wr_data,
    output logic                               busy
);

    localparam int IDX_W = $clog2(MAX_SETS);

    cthm_pkg::set_entry_t mem [MAX_SETS];
    cthm_pkg::set_entry_t rd_data_reg;
    logic [IDX_W-1:0]     clr_addr_reg;
    logic                 busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == IDX_W'(MAX_SETS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= cthm_pkg::ENTRY_RESET;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

// ===== src/cthm_lookup.sv =====
// Lookup stage: tag compare, replacement, write-back with forwarding, hit and
// miss totals and the output register. Depends on cthm_pkg.
`default_nettype none

module cthm_lookup #(
    parameter int MAX_SETS = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          mode,
    input  wire logic                          in_accept,
    input  wire logic                          in_action,
    input  wire logic [$clog2(MAX_SETS)-1:0]   in_idx,
    input  wire logic [cthm_pkg::TAG_W-1:0]    in_tag,
    output logic                               ready,
    input  cthm_pkg::set_entry_t               rd_data,
    output logic                               wr_en,
    output logic      [$clog2(MAX_SETS)-1:0]   wr_addr,
    output cthm_pkg::set_entry_t               wr_data,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic                               hit,
    output logic      [cthm_pkg::COUNT_W-1:0]  hit_count,
    output logic      [cthm_pkg::COUNT_W-1:0]  miss_count
);

    localparam int IDX_W = $clog2(MAX_SETS);

    logic                            s1_valid_reg;
    logic                            s1_action_reg;
    logic [IDX_W-1:0]                s1_idx_reg;
    logic [cthm_pkg::TAG_W-1:0]      s1_tag_reg;
    logic                            fwd_valid_reg;
    logic [IDX_W-1:0]                fwd_idx_reg;
    cthm_pkg::set_entry_t            fwd_entry_reg;
    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [cthm_pkg::COUNT_W-1:0]    hit_total_reg;
    logic [cthm_pkg::COUNT_W-1:0]    miss_total_reg;

    logic                            advance;
    logic                            complete;
    logic                            h0;
    logic                            h1;
    logic                            hit_now;
    cthm_pkg::set_entry_t            cur_entry;
    cthm_pkg::set_entry_t            upd_entry;

    assign advance  = !out_valid_reg || !out_stall;
    assign complete = s1_valid_reg && advance;
    assign ready    = !s1_valid_reg || advance;

    // The memory read of a request races the write-back of the request just
    // before it; the last written entry stands in for the stale read.
    assign cur_entry = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg) ? fwd_entry_reg : rd_data;

    always_comb
    begin
        h0        = cur_entry.v0 && cur_entry.t0 == s1_tag_reg;
        h1        = cur_entry.v1 && cur_entry.t1 == s1_tag_reg;
        upd_entry = cur_entry;
        hit_now   = 1'b0;
        if (mode == cthm_pkg::MODE_DIRECT)
        begin
            if (h0)
            begin
                hit_now = 1'b1;
            end
            else if (s1_action_reg == cthm_pkg::ACT_READ)
            begin
                upd_entry.v0 = 1'b1;
                upd_entry.t0 = s1_tag_reg;
            end
        end
        else
        begin
            if (h0)
            begin
                hit_now          = 1'b1;
                upd_entry.recent = 1'b0;
            end
            else if (h1)
            begin
                hit_now          = 1'b1;
                upd_entry.recent = 1'b1;
            end
            else if (cur_entry.recent)
            begin
                upd_entry.v0     = 1'b1;
                upd_entry.t0     = s1_tag_reg;
                upd_entry.recent = 1'b0;
            end
            else
            begin
                upd_entry.v1     = 1'b1;
                upd_entry.t1     = s1_tag_reg;
                upd_entry.recent = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (complete)
            begin
                fwd_valid_reg <= 1'b1;
                if (hit_now)
                begin
                    hit_total_reg <= hit_total_reg + 1'b1;
                end
                else
                begin
                    miss_total_reg <= miss_total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= in_action;
            s1_idx_reg    <= in_idx;
            s1_tag_reg    <= in_tag;
        end
        if (complete)
        begin
            fwd_idx_reg   <= s1_idx_reg;
            fwd_entry_reg <= upd_entry;
            hit_reg       <= hit_now;
        end
    end

    assign wr_en      = complete;
    assign wr_addr    = s1_idx_reg;
    assign wr_data    = upd_entry;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    // The totals change only when a result loads the output register.
    assign hit_count  = hit_total_reg;
    assign miss_count = miss_total_reg;

endmodule

`default_nettype wire

// ===== src/cache_tag_hit_miss_model_top.sv =====
// Cache tag hit/miss model, top level: configuration registers and the
// decode, tag store and lookup parts.
//
// Requests (action, address) enter on in_valid/in_stall; one result per
// request (hit, hit_count, miss_count) leaves on out_valid/out_stall.
// Mode 0 is a 1 KB direct-mapped cache without write allocate, mode 1 a
// 4 KB two-way cache that replaces the less recently used way.
// A request taken at a clock edge reads its set from the tag store and enters
// the lookup stage; its result loads the output register when that is free,
// and the receiver takes it from there. One request is taken per cycle while
// the output is not stalled; the read of the next set overlaps the write-back
// of the current one, and the last written set is forwarded on a shared index.
// After reset the tag store is swept clear, one set per cycle, through
// all MAX_SETS sets; in_stall stays high during the sweep.
// While out_stall holds a result, one more request can be taken into the
// lookup stage; after that in_stall rises until the output drains.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no request is in flight; the block does not enforce it.
`default_nettype none

module cache_tag_hit_miss_model_top #(
    parameter int MAX_SETS = 512
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [cthm_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [cthm_pkg::ADDR_W-1:0]       address,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic      [cthm_pkg::COUNT_W-1:0]      hit_count,
    output logic      [cthm_pkg::COUNT_W-1:0]      miss_count
);

    localparam int IDX_W = $clog2(MAX_SETS);

    logic                          mode_reg;
    logic [cthm_pkg::CFG_W-1:0]    offset_bits_reg;
    logic                          in_accept;
    logic [IDX_W-1:0]              dec_idx;
    logic [cthm_pkg::TAG_W-1:0]    dec_tag;
    cthm_pkg::set_entry_t          rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    cthm_pkg::set_entry_t          wr_data;
    logic                          ram_busy;
    logic                          lk_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cthm_pkg::MODE_DIRECT;
            offset_bits_reg <= cthm_pkg::RESET_OFFSET_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cthm_pkg::CFG_MODE:         mode_reg        <= cfg_data[0];
                cthm_pkg::CFG_BLOCK_OFFSET: offset_bits_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign in_stall  = ram_busy || !lk_ready;
    assign in_accept = in_valid && !in_stall;

    cthm_index #(
        .MAX_SETS (MAX_SETS)
    ) u_index (
        .mode        (mode_reg),
        .offset_bits (offset_bits_reg),
        .address     (address),
        .idx         (dec_idx),
        .tag         (dec_tag)
    );

    cthm_tag_ram #(
        .MAX_SETS (MAX_SETS)
    ) u_tag_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (dec_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (ram_busy)
    );

    cthm_lookup #(
        .MAX_SETS (MAX_SETS)
    ) u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_accept  (in_accept),
        .in_action  (action),
        .in_idx     (dec_idx),
        .in_tag     (dec_tag),
        .ready      (lk_ready),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .hit        (hit),
        .hit_count  (hit_count),
        .miss_count (miss_count)
    );

endmodule

`default_nettype wire

// ===== src/cthm_checker.sv =====
// Port-level checker for the cache tag hit/miss model, bound to the top level.
// Depends on cthm_pkg and the assertion macros header.
`default_nettype none

`include "cache_tag_hit_miss_model_top_macros.svh"

module cthm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              hit,
    input wire logic [cthm_pkg::COUNT_W-1:0]      hit_count,
    input wire logic [cthm_pkg::COUNT_W-1:0]      miss_count
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // A result held by the receiver keeps its payload.
    `CTHM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hit) && $stable(hit_count) && $stable(miss_count))

    // Each new result bumps exactly the counter that its hit flag names.
    `CTHM_ASSERT_IMPLY(a_count_step, clk, rst_n, out_acc ##1 out_valid, (hit && hit_count == $past(hit_count) + 32'd1 && miss_count == $past(miss_count)) || (!hit && miss_count == $past(miss_count) + 32'd1 && hit_count == $past(hit_count)))

    // An accepted request moves into the output register whenever the output is free.
    `CTHM_ASSERT_NEXT(a_latency, clk, rst_n, in_acc ##1 (!out_valid || !out_stall), out_valid)

    // No result appears without a request in flight.
    `CTHM_ASSERT_NEXT(a_no_invent, clk, rst_n, !in_acc ##1 (!out_valid && !in_acc), !out_valid)

endmodule

bind cache_tag_hit_miss_model_top cthm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .hit_count  (hit_count),
    .miss_count (miss_count)
);

`default_nettype wire
